// ===== hw/rtl/hps_pkg.sv =====
// Package for the hybrid process scheduler: shared constants, types, codes.
// No dependencies.
package hps_pkg;

	localparam int DefMaxProcs = 16;
	localparam logic [15:0] QuantumReset = 16'd3;
	localparam logic [4:0] SjnReset = 5'd2;
	localparam logic [4:0] PrioReset = 5'd5;

	localparam logic [1:0] CfgQuantum = 2'd0;
	localparam logic [1:0] CfgSjn = 2'd1;
	localparam logic [1:0] CfgPrio = 2'd2;

	localparam logic [1:0] KindRan = 2'd0;
	localparam logic [1:0] KindIdle = 2'd1;
	localparam logic [1:0] KindDone = 2'd2;
	localparam logic [1:0] KindAdmit = 2'd3;

	localparam logic [1:0] PolShortest = 2'd0;
	localparam logic [1:0] PolPriority = 2'd1;
	localparam logic [1:0] PolFirst = 2'd2;

	typedef struct packed {
		logic        func;
		logic [3:0]  proc_id;
		logic [15:0] arrival_time;
		logic [15:0] burst_time;
		logic [7:0]  prio_value;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  run_pid;
		logic [15:0] run_time;
		logic [31:0] now_time;
		logic        done_flag;
		logic [31:0] turnaround;
		logic [31:0] waiting;
	} res_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_ADMIT_FIND, ST_ADMIT_SHIFT, ST_ADMIT_WR, ST_SCAN, ST_EMPTY,
		ST_SORT_OUT, ST_SORT_CMP, ST_PICK, ST_SHIFT, ST_RUN, ST_FIN, ST_EMIT
	} state_t;

endpackage

// ===== hw/rtl/hps_cmd_fifo.sv =====
// Command queue between the intake front and the scheduling engine.
// Depends on hps_pkg.
module hps_cmd_fifo import hps_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  cmd_t wr_data,
	output logic full,
	input  logic rd_en,
	output cmd_t rd_data,
	output logic rd_valid
);
	cmd_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full = cnt_q == 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (wr_en) wp_q <= ~wp_q;
			if (rd_en) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
		end
	end
endmodule

// ===== hw/rtl/hps_engine.sv =====
// Scheduling engine: process table, ready queue, sequencer and result register.
// Depends on hps_pkg.
module hps_engine import hps_pkg::*; #(
	parameter int MAX_PROCS = DefMaxProcs
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	input  cmd_t        cmd,
	output logic        cmd_take,
	input  logic [15:0] quantum,
	input  logic [4:0]  sjn_limit,
	input  logic [4:0]  priority_limit,
	output logic        res_valid,
	output res_t        res,
	input  logic        res_take
);
	localparam int IW = $clog2(MAX_PROCS);
	localparam int CW = $clog2(MAX_PROCS + 1);

	logic [15:0] arr_q [MAX_PROCS];
	logic [15:0] bur_q [MAX_PROCS];
	logic [15:0] rem_q [MAX_PROCS];
	logic [7:0]  pri_q [MAX_PROCS];
	logic [IW-1:0] ord_q [MAX_PROCS];
	logic [MAX_PROCS-1:0] adm_q, que_q, fin_q;
	logic [CW-1:0] cnt_q;
	logic [31:0] clk_q;

	state_t st_q, st_d;
	cmd_t cmd_q;
	logic [CW-1:0] i_q, j_q;
	logic [IW-1:0] v_q, slot_q;
	logic [15:0] key_q, run_q;
	logic [1:0] pol_q;
	logic rv_q;
	res_t res_q, work_q;

	logic id_ok, adm_hit, shift_more, sort_move, scan_ok, emit_go;
	logic [IW-1:0] cid, iidx, jm1;
	logic [15:0] kprev;

	assign res_valid = rv_q;
	assign res = res_q;
	assign cmd_take = (st_q == ST_IDLE) && cmd_valid;

	function automatic logic [15:0] keyof(input logic [1:0] p, input logic [15:0] r,
		input logic [7:0] q);
		keyof = (p == PolShortest) ? r : {8'd0, q};
	endfunction

	function automatic res_t pack_res(input logic [1:0] k, input logic [3:0] pid,
		input logic [15:0] rt, input logic [31:0] nw, input logic d,
		input logic [31:0] ta, input logic [31:0] wt);
		pack_res = '{k, pid, rt, nw, d, ta, wt};
	endfunction

	always_comb begin
		id_ok = {28'd0, cmd_q.proc_id} < 32'(MAX_PROCS);
		cid = IW'(cmd_q.proc_id);
		iidx = i_q[IW-1:0];
		jm1 = IW'(j_q - CW'(1));
		kprev = keyof(pol_q, rem_q[ord_q[jm1]], pri_q[ord_q[jm1]]);
		scan_ok = adm_q[iidx] && !que_q[iidx] && !fin_q[iidx] && ({16'd0, arr_q[iidx]} <= clk_q);
		adm_hit = ord_q[iidx] == cid;
		shift_more = (i_q + CW'(1)) < cnt_q;
		sort_move = (j_q != '0) && (kprev > key_q);
		// result register frees up either empty or by a transfer this cycle
		emit_go = (st_q == ST_EMIT) && (!rv_q || res_take);
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE:        if (cmd_take) st_d = cmd.func ? ST_SCAN : ST_ADMIT_FIND;
			ST_ADMIT_FIND: begin
				if (!id_ok) st_d = ST_EMIT;
				else if (!que_q[cid] || i_q >= cnt_q) st_d = ST_ADMIT_WR;
				else if (adm_hit) st_d = ST_ADMIT_SHIFT;
			end
			ST_ADMIT_SHIFT: if (!shift_more) st_d = ST_ADMIT_WR;
			ST_ADMIT_WR:    st_d = ST_EMIT;
			ST_SCAN:        if (i_q == CW'(MAX_PROCS - 1)) st_d = ST_EMPTY;
			ST_EMPTY:       st_d = (cnt_q == '0) ? ST_EMIT : ST_SORT_OUT;
			ST_SORT_OUT:    st_d = (pol_q == PolFirst || i_q >= cnt_q) ? ST_PICK : ST_SORT_CMP;
			ST_SORT_CMP:    if (!sort_move) st_d = ST_SORT_OUT;
			ST_PICK:        st_d = ST_SHIFT;
			ST_SHIFT:       if (!shift_more) st_d = ST_RUN;
			ST_RUN:         st_d = ST_FIN;
			ST_FIN:         st_d = ST_EMIT;
			ST_EMIT:        if (emit_go) st_d = ST_IDLE;
			default:        st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd_take) cmd_q <= cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE; adm_q <= '0; que_q <= '0; fin_q <= '0;
			cnt_q <= '0; clk_q <= '0; rv_q <= 1'b0;
			i_q <= '0; j_q <= '0; v_q <= '0; slot_q <= '0; key_q <= '0; run_q <= '0;
			pol_q <= '0; res_q <= '0; work_q <= '0;
		end else begin
			st_q <= st_d;
			if (emit_go) rv_q <= 1'b1;
			else if (res_take) rv_q <= 1'b0;
			if (emit_go) res_q <= work_q;
			unique case (st_q)
				ST_IDLE: if (cmd_take) i_q <= '0;
				ST_ADMIT_FIND: begin
					if (!id_ok)
						work_q <= pack_res(KindAdmit, 4'd0, 16'd0, clk_q, 1'b0, 32'd0, 32'd0);
					else if (que_q[cid] && i_q < cnt_q && !adm_hit) i_q <= i_q + CW'(1);
				end
				ST_ADMIT_SHIFT: begin
					if (shift_more) begin
						ord_q[iidx] <= ord_q[IW'(i_q + CW'(1))];
						i_q <= i_q + CW'(1);
					end else begin
						cnt_q <= cnt_q - CW'(1);
					end
				end
				ST_ADMIT_WR: begin
					arr_q[cid] <= cmd_q.arrival_time; bur_q[cid] <= cmd_q.burst_time;
					rem_q[cid] <= cmd_q.burst_time; pri_q[cid] <= cmd_q.prio_value;
					adm_q[cid] <= 1'b1; que_q[cid] <= 1'b0; fin_q[cid] <= 1'b0;
					work_q <= pack_res(KindAdmit, 4'd0, 16'd0, clk_q, 1'b0, 32'd0, 32'd0);
				end
				ST_SCAN: begin
					if (scan_ok && cnt_q < CW'(MAX_PROCS)) begin
						ord_q[cnt_q[IW-1:0]] <= iidx;
						cnt_q <= cnt_q + CW'(1);
						que_q[iidx] <= 1'b1;
					end
					if (i_q != CW'(MAX_PROCS - 1)) i_q <= i_q + CW'(1);
				end
				ST_EMPTY: begin
					if (cnt_q == '0) begin
						if ((adm_q & ~fin_q) == '0) begin
							work_q <= pack_res(KindDone, 4'd0, 16'd0, clk_q, 1'b0, 32'd0, 32'd0);
						end else begin
							work_q <= pack_res(KindIdle, 4'd0, 16'd0, clk_q + 32'd1, 1'b0,
								32'd0, 32'd0);
							clk_q <= clk_q + 32'd1;
						end
					end else begin
						if (32'(cnt_q) <= 32'(sjn_limit)) pol_q <= PolShortest;
						else if (32'(cnt_q) <= 32'(priority_limit)) pol_q <= PolPriority;
						else pol_q <= PolFirst;
						i_q <= CW'(1);
					end
				end
				ST_SORT_OUT: begin
					if (pol_q != PolFirst && i_q < cnt_q) begin
						v_q <= ord_q[iidx];
						key_q <= keyof(pol_q, rem_q[ord_q[iidx]], pri_q[ord_q[iidx]]);
						j_q <= i_q;
					end
				end
				ST_SORT_CMP: begin
					if (sort_move) begin
						ord_q[j_q[IW-1:0]] <= ord_q[jm1];
						j_q <= j_q - CW'(1);
					end else begin
						ord_q[j_q[IW-1:0]] <= v_q;
						i_q <= i_q + CW'(1);
					end
				end
				ST_PICK: begin
					slot_q <= ord_q[0];
					i_q <= '0;
				end
				ST_SHIFT: begin
					if (shift_more) begin
						ord_q[iidx] <= ord_q[IW'(i_q + CW'(1))];
						i_q <= i_q + CW'(1);
					end else begin
						cnt_q <= cnt_q - CW'(1);
						que_q[slot_q] <= 1'b0;
						run_q <= (quantum < rem_q[slot_q]) ? quantum : rem_q[slot_q];
					end
				end
				ST_RUN: begin
					rem_q[slot_q] <= rem_q[slot_q] - run_q;
					clk_q <= clk_q + {16'd0, run_q};
				end
				ST_FIN: begin
					if (rem_q[slot_q] == 16'd0) begin
						fin_q[slot_q] <= 1'b1;
						work_q <= pack_res(KindRan, 4'(slot_q), run_q, clk_q, 1'b1,
							clk_q - {16'd0, arr_q[slot_q]},
							clk_q - {16'd0, arr_q[slot_q]} - {16'd0, bur_q[slot_q]});
					end else begin
						work_q <= pack_res(KindRan, 4'(slot_q), run_q, clk_q, 1'b0, 32'd0, 32'd0);
						ord_q[cnt_q[IW-1:0]] <= slot_q;
						cnt_q <= cnt_q + CW'(1);
						que_q[slot_q] <= 1'b1;
					end
				end
				ST_EMIT: ;
				default: ;
			endcase
		end
	end
endmodule

// ===== hw/rtl/hybrid_process_scheduler.sv =====
// Top level of the hybrid process scheduler: config registers, intake queue,
// engine with result register. Depends on hps_pkg, hps_cmd_fifo, hps_engine.
//
// Usage: push a command (func 0 admit, 1 dispatch) while full is low; one
// result per command appears on the result ports while empty is low and is
// removed with pop. Config writes (cfg_valid/cfg_ready, cfg_index, cfg_data)
// are always accepted and must happen only while idle.
// An admit of an unqueued slot goes straight to the table write; an admit of a
// queued slot first searches the queue and closes it up. A dispatch scans the
// table one slot per cycle, then gives an idle tick or all-done result if
// nothing is queued, or else a run, picked first-come or after the stable
// insertion sort. The engine works one command at a time.
// A two-entry intake queue accepts commands while the engine runs.
// Reset clears the process flags, queue count, clock and config to defaults.
// If pop is held low the result waits; the engine still carries out the next
// command and holds its result until the waiting one is taken.
module hybrid_process_scheduler import hps_pkg::*; #(
	parameter int MAX_PROCS = DefMaxProcs
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        func,
	input  logic [3:0]  proc_id,
	input  logic [15:0] arrival_time,
	input  logic [15:0] burst_time,
	input  logic [7:0]  prio_value,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  kind,
	output logic [3:0]  run_pid,
	output logic [15:0] run_time,
	output logic [31:0] now_time,
	output logic        done_flag,
	output logic [31:0] turnaround,
	output logic [31:0] waiting,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	logic [15:0] quantum_q;
	logic [4:0] sjn_q, prio_q;
	cmd_t in_cmd, f_cmd;
	logic f_valid, f_take, rvalid;
	res_t r;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q <= QuantumReset; sjn_q <= SjnReset; prio_q <= PrioReset;
		end else if (cfg_valid) begin
			case (cfg_index)
				CfgQuantum: quantum_q <= cfg_data;
				CfgSjn:     sjn_q <= cfg_data[4:0];
				CfgPrio:    prio_q <= cfg_data[4:0];
				default:    ;
			endcase
		end
	end

	assign in_cmd = '{func, proc_id, arrival_time, burst_time, prio_value};

	hps_cmd_fifo u_fifo (
		.clk, .arst_n, .wr_en(push && !full), .wr_data(in_cmd), .full,
		.rd_en(f_take), .rd_data(f_cmd), .rd_valid(f_valid)
	);

	hps_engine #(.MAX_PROCS(MAX_PROCS)) u_eng (
		.clk, .arst_n, .cmd_valid(f_valid), .cmd(f_cmd), .cmd_take(f_take),
		.quantum(quantum_q), .sjn_limit(sjn_q), .priority_limit(prio_q),
		.res_valid(rvalid), .res(r), .res_take(pop && !empty)
	);

	assign empty = !rvalid;
	assign kind = r.kind;
	assign run_pid = r.run_pid;
	assign run_time = r.run_time;
	assign now_time = r.now_time;
	assign done_flag = r.done_flag;
	assign turnaround = r.turnaround;
	assign waiting = r.waiting;
endmodule

// ===== hw/rtl/hps_checker.sv =====
// Port-level checker for the hybrid process scheduler, bound to the top level.
// Depends on hps_pkg.
module hps_checker import hps_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic [1:0]  kind,
	input logic        done_flag,
	input logic [15:0] run_time,
	input logic [31:0] turnaround
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(kind)) else $error("result dropped");
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && done_flag |-> kind == KindRan) else $error("done on non-run");
	a_rt: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && kind != KindRan |-> run_time == 16'd0) else $error("run time on non-run");
	a_ta: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !done_flag |-> turnaround == 32'd0) else $error("stray turnaround");
endmodule

bind hybrid_process_scheduler hps_checker u_chk (
	.clk, .arst_n, .empty, .pop, .kind, .done_flag, .run_time, .turnaround
);
